>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: request codes,
// status codes and the request/response payload structs.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DefaultDepth = 128;
  localparam int unsigned WordW        = 32;
  localparam int unsigned OccW         = 8;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e               req_type;
    logic signed [WordW-1:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [WordW-1:0] pop_value;
    logic                    pop_valid;
    status_e                 status;
    logic [OccW-1:0]         occupancy;
  } deq_rsp_t;

endpackage

>>> src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept in a circular on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_req_i): each request
//   pushes at the back, pushes at the front, pops the front or pops the
//   back. Response channel (out_valid_o / out_stall_i / out_rsp_o): exactly
//   one response per request, in order, with the popped word (zero when
//   none), a pop_valid flag, a status code and the occupancy after the
//   request (modulo 256).
//   Path: an accepted request enters the read stage together with its
//   memory read, if any, then moves into the response register on the port.
//   Throughput: one request per cycle while the receiver does not stall.
//   Head and count update at accept, so back-to-back requests chain
//   without bubbles; a push and a later pop never touch the memory in the
//   same cycle, so no forwarding is needed. The rate is set by the
//   single-port-per-direction word memory.
//   Stall: while the receiver stalls, the response register holds and one
//   more request is taken into the read stage; after that in_stall_o rises.
//   Reset: head and count clear (queue empty) and both stages empty out.
//   The memory contents are not cleared; they are only read after a push.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  deq_pkg::deq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output deq_pkg::deq_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  // Queue state
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  // Word store and its registered read port
  logic [deq_pkg::WordW-1:0] mem_q [DEPTH];
  logic [deq_pkg::WordW-1:0] rdata_q;

  // Read stage: response fields waiting on the memory data
  logic                        pend_q;
  logic                        pend_pop_q;
  deq_pkg::status_e            pend_status_q;
  logic [deq_pkg::OccW-1:0]    pend_occ_q;

  // Response register
  logic              out_valid_q;
  deq_pkg::deq_rsp_t out_rsp_q;

  logic accept, pend_move;
  logic is_push, is_full, is_empty;
  logic mem_we, mem_re;
  logic [IdxW-1:0] waddr, raddr, back_slot, head_dec, head_inc;
  logic [SumW-1:0] back_sum, back_wrap;
  logic [CntW-1:0] back_off;
  logic            pop_ok;
  deq_pkg::status_e status_d;
  logic [CntW+deq_pkg::OccW-1:0] occ_wide;

  // Advance the read stage when the response register is free or draining
  assign pend_move  = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !pend_move;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_push  = (in_req_i.req_type == deq_pkg::REQ_PUSH_BACK) ||
                    (in_req_i.req_type == deq_pkg::REQ_PUSH_FRONT);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Back slot: head + count for a back push, head + count - 1 for a back pop
  assign back_off  = (in_req_i.req_type == deq_pkg::REQ_PUSH_BACK) ? count_q
                                                                  : count_q - 1'b1;
  assign back_sum  = SumW'(head_q) + SumW'(back_off);
  assign back_wrap = (back_sum >= SumW'(DEPTH)) ? back_sum - SumW'(DEPTH) : back_sum;
  assign back_slot = back_wrap[IdxW-1:0];

  assign head_dec = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = back_slot;
    raddr    = back_slot;
    pop_ok   = 1'b0;
    status_d = deq_pkg::STATUS_OK;
    if (accept) begin
      case (in_req_i.req_type)
        deq_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        deq_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            waddr   = head_dec;
            head_d  = head_dec;
            count_d = count_q + 1'b1;
          end
        end
        deq_pkg::REQ_POP_FRONT: begin
          if (is_empty) begin
            status_d = deq_pkg::STATUS_EMPTY;
          end else begin
            mem_re  = 1'b1;
            pop_ok  = 1'b1;
            raddr   = head_q;
            head_d  = head_inc;
            count_d = count_q - 1'b1;
          end
        end
        deq_pkg::REQ_POP_BACK: begin
          if (is_empty) begin
            status_d = deq_pkg::STATUS_EMPTY;
          end else begin
            mem_re  = 1'b1;
            pop_ok  = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          status_d = deq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // Occupancy is reported modulo 256
  assign occ_wide = {{deq_pkg::OccW{1'b0}}, count_d};

  // Word memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= in_req_i.push_value;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the read stage until it moves on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_pop_q    <= pop_ok;
      pend_status_q <= status_d;
      pend_occ_q    <= occ_wide[deq_pkg::OccW-1:0];
    end
    if (pend_move) begin
      out_rsp_q.pop_value <= pend_pop_q ? rdata_q : '0;
      out_rsp_q.pop_valid <= pend_pop_q;
      out_rsp_q.status    <= pend_status_q;
      out_rsp_q.occupancy <= pend_occ_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> !in_stall_o)
    else $error("request stalled with empty read stage");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_push && !is_full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("successful push did not grow the queue");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.pop_valid) |-> (out_rsp_o.status == deq_pkg::STATUS_OK))
    else $error("popped word with non-ok status");

endmodule
